@@ sv/fixed_timestep_accumulator_defines.svh @@
// Assertion macros shared by the fixed-timestep accumulator RTL.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef FIXED_TIMESTEP_ACCUMULATOR_DEFINES_SVH
`define FIXED_TIMESTEP_ACCUMULATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Checked property, disabled while reset is asserted.
`define FTA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property, also active during reset.
`define FTA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FTA_ASSERT(lbl, prop, msg)
`define FTA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ sv/fta_pkg.sv @@
// Shared types and constants of the fixed-timestep accumulator.
// Used by fta_ctrl, fta_dpath and fixed_timestep_accumulator; no dependencies.
package fta_pkg;

  // Fixed field widths.
  localparam int FRAME_W   = 32;
  localparam int STEP_W    = 32;
  localparam int COUNT_W   = 8;
  localparam int CFG_IDX_W = 1;

  // Defaults for the top-level parameters.
  localparam int TIME_BITS_DEF  = 32;
  localparam int ALPHA_BITS_DEF = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CATCHUP = 1'b1;

  // Configuration reset values.
  localparam logic [STEP_W-1:0]  STEP_LENGTH_RST = 32'd16666667;
  localparam logic [COUNT_W-1:0] MAX_CATCHUP_RST = 8'd5;

  // Input command codes.
  localparam logic CMD_ACCUMULATE = 1'b0;
  localparam logic CMD_CLEAR      = 1'b1;

  // Controller states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_FRAC = 4'b0100,
    ST_FIN  = 4'b1000
  } fta_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // take a new input transaction
    logic clear;      // the loaded transaction is a clear command
    logic div_step;   // one quotient bit of the accumulator division
    logic frac_step;  // one fraction bit of remainder / step
    logic save_rem;   // keep the division remainder as the new accumulator
    logic out_load;   // write the result into the output register
  } fta_cmd_t;

endpackage

@@ sv/fta_dpath.sv @@
// Datapath of the fixed-timestep accumulator: configuration registers,
// accumulator, shared restoring divider and output register. Uses fta_pkg.
module fta_dpath
  import fta_pkg::*;
#(
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int ALPHA_BITS = ALPHA_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fta_cmd_t              cmd,
  input  logic [FRAME_W-1:0]    frame_time,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [STEP_W-1:0]     cfg_data,
  output logic [COUNT_W-1:0]    step_count,
  output logic [ALPHA_BITS-1:0] alpha
);

  localparam int SUM_W = ((TIME_BITS > FRAME_W) ? TIME_BITS : FRAME_W) + 1;

  logic [STEP_W-1:0]     step_length_r;
  logic [COUNT_W-1:0]    max_catchup_r;
  logic [TIME_BITS-1:0]  time_rem_r;
  logic [TIME_BITS-1:0]  dq_r;
  logic [STEP_W-1:0]     rem_r;
  logic [ALPHA_BITS-1:0] frac_r;
  logic [COUNT_W-1:0]    step_count_r;
  logic [ALPHA_BITS-1:0] alpha_r;

  logic [STEP_W-1:0]     step_eff;
  logic                  ft_pos;
  logic [SUM_W-1:0]      sum;
  logic [TIME_BITS-1:0]  acc;
  logic                  shift_bit;
  logic [STEP_W:0]       trial;
  logic [STEP_W-1:0]     diff;
  logic                  ge;
  logic [STEP_W-1:0]     rem_nxt;
  logic [COUNT_W-1:0]    clamped;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_length_r <= STEP_LENGTH_RST;
      max_catchup_r <= MAX_CATCHUP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEP_LENGTH: step_length_r <= cfg_data;
        CFG_MAX_CATCHUP: max_catchup_r <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero step length behaves as a step of one time unit.
  assign step_eff = (step_length_r == '0) ? STEP_W'(1) : step_length_r;

  // Saturating add of a positive frame duration to the accumulator.
  assign ft_pos = !frame_time[FRAME_W-1] && (frame_time != '0);
  assign sum    = SUM_W'(time_rem_r) + (ft_pos ? SUM_W'(frame_time) : '0);
  assign acc    = (|sum[SUM_W-1:TIME_BITS]) ? '1 : sum[TIME_BITS-1:0];

  // Shared restoring subtract step: dividend bits during the division,
  // zeros during the fraction. When the subtraction is taken the difference
  // is below the step, so its low bits are enough.
  assign shift_bit = cmd.div_step ? dq_r[TIME_BITS-1] : 1'b0;
  assign trial     = {rem_r, shift_bit};
  assign diff      = trial[STEP_W-1:0] - step_eff;
  assign ge        = (trial >= {1'b0, step_eff});
  assign rem_nxt   = ge ? diff : trial[STEP_W-1:0];

  // Clamp of the whole-step count to the catch-up limit.
  assign clamped = (dq_r > TIME_BITS'(max_catchup_r)) ? max_catchup_r : dq_r[COUNT_W-1:0];

  // Carried remainder.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_rem_r <= '0;
    end else if (cmd.load && cmd.clear) begin
      time_rem_r <= '0;
    end else if (cmd.save_rem) begin
      time_rem_r <= TIME_BITS'(rem_nxt);
    end
  end

  // Divider working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dq_r   <= cmd.clear ? '0 : acc;
      rem_r  <= '0;
      frac_r <= '0;
    end else if (cmd.div_step) begin
      dq_r  <= {dq_r[TIME_BITS-2:0], ge};
      rem_r <= rem_nxt;
    end else if (cmd.frac_step) begin
      frac_r <= {frac_r[ALPHA_BITS-2:0], ge};
      rem_r  <= rem_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      step_count_r <= clamped;
      alpha_r      <= frac_r;
    end
  end

  assign step_count = step_count_r;
  assign alpha      = alpha_r;

endmodule

@@ sv/fta_ctrl.sv @@
// Controller of the fixed-timestep accumulator: sequences load, division,
// fraction and output write. Uses fta_pkg and the assertion macro header.
`include "fixed_timestep_accumulator_defines.svh"

module fta_ctrl
  import fta_pkg::*;
#(
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int ALPHA_BITS = ALPHA_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_command,
  output logic     out_valid,
  input  logic     out_ready,
  output fta_cmd_t cmd
);

  localparam int MAX_N = (TIME_BITS > ALPHA_BITS) ? TIME_BITS : ALPHA_BITS;
  localparam int CNT_W = $clog2(MAX_N);

  fta_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;
  logic             take_clear;

  assign in_ready   = (state_r == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign take_clear = accept && (in_command == CMD_CLEAR);

  // Next state, iteration counter and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          cmd.clear = take_clear;
          cnt_nxt   = CNT_W'(TIME_BITS - 1);
          state_nxt = take_clear ? ST_FIN : ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          cmd.save_rem = 1'b1;
          cnt_nxt      = CNT_W'(ALPHA_BITS - 1);
          state_nxt    = ST_FRAC;
        end
      end
      ST_FRAC: begin
        cmd.frac_step = 1'b1;
        cnt_nxt       = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // The output register holds a result until its transaction completes.
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // A clear command skips the division and goes straight to the output write.
  `FTA_ASSERT(a_clear_to_fin, take_clear |=> (state_r == ST_FIN), "clear not sent to output")
  // A result is never written over one that is still waiting.
  `FTA_ASSERT(a_no_overwrite, cmd.out_load |-> (!out_valid_r || out_ready), "result overwritten")
  // After an output write the block is idle with a valid result.
  `FTA_ASSERT(a_load_then_idle, cmd.out_load |=> (in_ready && out_valid_r), "no idle after write")
  // The remainder is saved exactly when the division leaves for the fraction.
  `FTA_ASSERT(a_save_rem, cmd.save_rem |=> (state_r == ST_FRAC), "remainder saved out of place")
  // Division and fraction steps never share a cycle.
  `FTA_ASSERT_ALWAYS(a_one_step, !(cmd.div_step && cmd.frac_step), "two steps in one cycle")

endmodule

@@ sv/fixed_timestep_accumulator.sv @@
// Fixed-timestep accumulator with catch-up clamp: top level.
// Depends on fta_pkg, fta_ctrl and fta_dpath.
//
// Each accumulate transaction adds a positive frame duration to the carried
// remainder (saturating at 2^TIME_BITS - 1), divides it by step_length and
// returns the whole-step count clamped to max_catchup together with the
// fraction remainder/step_length in ALPHA_BITS bits, truncated. A clear
// transaction zeroes the remainder and returns zeros. One item is in work at
// a time: an accumulate transaction runs through the division and then the
// fraction on the single one-bit-per-cycle restoring subtractor shared by
// both; a clear skips them and goes straight to the output write. A finished
// result waits in an output register, and the next item is accepted while
// it waits. Configuration writes are always taken and must happen only while
// the block is idle.
module fixed_timestep_accumulator
  import fta_pkg::*;
#(
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int ALPHA_BITS = ALPHA_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_command,
  input  logic signed [FRAME_W-1:0]   in_frame_time,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [COUNT_W-1:0]          out_step_count,
  output logic [ALPHA_BITS-1:0]       out_alpha,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [STEP_W-1:0]           cfg_data
);

  fta_cmd_t cmd;

  assign cfg_ready = 1'b1;

  // Sequencer.
  fta_ctrl #(
    .TIME_BITS  (TIME_BITS),
    .ALPHA_BITS (ALPHA_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd)
  );

  // Accumulator, divider and output register.
  fta_dpath #(
    .TIME_BITS  (TIME_BITS),
    .ALPHA_BITS (ALPHA_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .frame_time (in_frame_time),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .step_count (out_step_count),
    .alpha      (out_alpha)
  );

endmodule

@@ dv/fta_result_checker.sv @@
// Result checker for the fixed-timestep accumulator: watches the three channels,
// predicts each frame result and compares it with what the block returns.
// Depends on fta_pkg.
module fta_result_checker
  import fta_pkg::*;
#(
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int ALPHA_BITS = ALPHA_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic                      in_command,
  input  logic signed [FRAME_W-1:0] in_frame_time,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [COUNT_W-1:0]        out_step_count,
  input  logic [ALPHA_BITS-1:0]     out_alpha,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [STEP_W-1:0]         cfg_data,
  output int                        mismatch_count,
  output int                        results_owed
);

  typedef struct packed {
    logic [COUNT_W-1:0]    steps;
    logic [ALPHA_BITS-1:0] alpha;
  } frame_result_t;

  // Private copy of the configuration and of the carried time.
  logic [STEP_W-1:0]    step_len;
  logic [COUNT_W-1:0]   catchup_max;
  logic [TIME_BITS-1:0] carried_time;

  // Results predicted but not yet returned, oldest first.
  frame_result_t owed_results[$];

  // Works out the result of one frame transaction and advances the carried time.
  function automatic frame_result_t next_frame_result(input logic cmd,
                                                      input logic signed [FRAME_W-1:0] ft);
    frame_result_t                   res;
    logic [TIME_BITS:0]              sum;
    logic [TIME_BITS-1:0]            total;
    logic [TIME_BITS-1:0]            whole;
    logic [STEP_W-1:0]               divisor;
    logic [TIME_BITS+ALPHA_BITS-1:0] scaled;
    res = '0;
    if (cmd == CMD_CLEAR) begin
      carried_time = '0;
      return res;
    end
    // Only a positive duration counts; the sum saturates at the top of the range.
    sum = {1'b0, carried_time};
    if (ft > 0) begin
      sum = sum + {1'b0, $unsigned(ft)};
    end
    total = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
    // A step length of zero behaves as one.
    divisor = (step_len == '0) ? STEP_W'(1) : step_len;
    whole = total / divisor;
    res.steps = (whole > catchup_max) ? catchup_max : whole[COUNT_W-1:0];
    carried_time = total % divisor;
    scaled = {carried_time, {ALPHA_BITS{1'b0}}} / divisor;
    res.alpha = scaled[ALPHA_BITS-1:0];
    return res;
  endfunction

  // Follow every transaction on the three channels at the clock edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      step_len       = STEP_LENGTH_RST;
      catchup_max    = MAX_CATCHUP_RST;
      carried_time   = '0;
      mismatch_count = 0;
      owed_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STEP_LENGTH: step_len = cfg_data;
          CFG_MAX_CATCHUP: catchup_max = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      // The returned result always belongs to an earlier frame, so compare first.
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          $display("%0t: result returned with none outstanding, actual steps %0d alpha %0d",
                   $time, out_step_count, out_alpha);
          mismatch_count++;
        end else begin
          frame_result_t exp_res;
          exp_res = owed_results.pop_front();
          if (out_step_count !== exp_res.steps) begin
            $display("%0t: step_count mismatch, expected %0d, actual %0d",
                     $time, exp_res.steps, out_step_count);
            mismatch_count++;
          end
          if (out_alpha !== exp_res.alpha) begin
            $display("%0t: alpha mismatch, expected %0d, actual %0d",
                     $time, exp_res.alpha, out_alpha);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        owed_results.push_back(next_frame_result(in_command, in_frame_time));
      end
    end
    results_owed = owed_results.size();
  end

endmodule

@@ dv/testbench.sv @@
// Top of the fixed-timestep accumulator testbench: clock, reset, stimulus and verdict.
// Depends on fta_pkg, fixed_timestep_accumulator and fta_result_checker.
module testbench;
  import fta_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 60;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic                      in_command;
  logic signed [FRAME_W-1:0] in_frame_time;
  logic                      out_valid;
  logic                      out_ready;
  logic [COUNT_W-1:0]        out_step_count;
  logic [ALPHA_BITS_DEF-1:0] out_alpha;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [STEP_W-1:0]         cfg_data;

  int mismatch_count;
  int results_owed;
  int cycle_count = 0;
  int sink_wait;
  int sink_draw;
  bit feed_steady;
  bit sink_steady;

  // Settings currently programmed, used to aim the frame durations.
  logic [STEP_W-1:0]  cur_step    = STEP_LENGTH_RST;
  logic [COUNT_W-1:0] cur_catchup = MAX_CATCHUP_RST;

  fixed_timestep_accumulator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_frame_time  (in_frame_time),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_step_count (out_step_count),
    .out_alpha      (out_alpha),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  fta_result_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_frame_time  (in_frame_time),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_step_count (out_step_count),
    .out_alpha      (out_alpha),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog on the length of the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** fixed_timestep_accumulator: FAILED **");
      $finish;
    end
  end

  // Result side: after each transaction hold ready low for a drawn number of cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      sink_wait <= 2;
    end else if (out_valid && out_ready) begin
      sink_draw = sink_steady ? 0 : $urandom_range(0, 7);
      out_ready <= (sink_draw == 0);
      sink_wait <= sink_draw;
    end else if (sink_wait > 0) begin
      out_ready <= (sink_wait == 1);
      sink_wait <= sink_wait - 1;
    end
  end

  // Offers one frame transaction after a drawn gap and returns at its acceptance edge.
  // Valid is left high so that a following transaction can follow without a gap.
  task automatic send_frame(input logic cmd, input logic signed [FRAME_W-1:0] ft);
    int gap;
    gap = feed_steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_frame_time <= ft;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering frames and waits until every owed result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
    @(posedge clk);
  endtask

  // Writes both registers back to back; only called while the block is idle.
  task automatic set_timing(input logic [STEP_W-1:0] step, input logic [COUNT_W-1:0] limit);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_STEP_LENGTH;
    cfg_data  <= step;
    do @(posedge clk); while (!cfg_ready);
    // Upper data bits are irrelevant for the catch-up limit, so fill them randomly.
    cfg_index <= CFG_MAX_CATCHUP;
    cfg_data  <= {(STEP_W-COUNT_W)'($urandom), limit};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    cur_step    = step;
    cur_catchup = limit;
  endtask

  // Draws a frame duration: mostly a few step lengths plus a fraction, the rest odd cases.
  function automatic logic signed [FRAME_W-1:0] pick_frame_time();
    logic [63:0] unit;
    logic [63:0] span;
    int          pick;
    unit = (cur_step == '0) ? 64'd1 : {32'd0, cur_step};
    pick = $urandom_range(0, 99);
    if (pick < 8) return $urandom;
    if (pick < 12) return '0;
    if (pick < 18) return {1'b1, 31'($urandom)};
    if (pick < 22) return 32'h7FFF_FFFF;
    if (pick < 26) return $urandom_range(1, 3);
    if ($urandom_range(0, 9) < 7) begin
      span = unit * $urandom_range(0, 2);
    end else begin
      span = unit * $urandom_range(0, cur_catchup + 4);
    end
    span = span + ((unit * $urandom_range(0, 65535)) >> 16);
    return {1'b0, span[FRAME_W-2:0]};
  endfunction

  // Random frames with occasional clears, changing idle behaviour in stretches.
  task automatic run_frames(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        feed_steady = ($urandom_range(0, 3) == 0);
        sink_steady <= ($urandom_range(0, 3) == 0);
      end
      // Halfway through, let the block run completely dry once.
      if (i == count / 2) begin
        wait_drained();
      end
      if ($urandom_range(0, 19) == 0) begin
        send_frame(CMD_CLEAR, $urandom);
      end else begin
        send_frame(CMD_ACCUMULATE, pick_frame_time());
      end
    end
    wait_drained();
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_command    <= CMD_ACCUMULATE;
    in_frame_time <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_STEP_LENGTH;
    cfg_data      <= '0;
    sink_steady   <= 1'b0;
    feed_steady   = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames at the reset settings: clear, ignored durations, exact steps, clamp.
    send_frame(CMD_CLEAR, 32'h7FFF_FFFF);
    send_frame(CMD_ACCUMULATE, 32'sd0);
    send_frame(CMD_ACCUMULATE, -32'sd1);
    send_frame(CMD_ACCUMULATE, 32'h8000_0000);
    send_frame(CMD_ACCUMULATE, 32'sd1);
    send_frame(CMD_ACCUMULATE, 32'sd16666666);
    send_frame(CMD_ACCUMULATE, 32'sd16666667);
    send_frame(CMD_ACCUMULATE, 32'h7FFF_FFFF);
    send_frame(CMD_ACCUMULATE, 32'sd8333333);
    send_frame(CMD_CLEAR, 32'sd0);
    wait_drained();

    // A zero step length counts every time unit as a step.
    set_timing('0, 8'd3);
    send_frame(CMD_ACCUMULATE, 32'sd2);
    send_frame(CMD_ACCUMULATE, 32'sd1000);
    send_frame(CMD_ACCUMULATE, 32'h7FFF_FFFF);
    wait_drained();

    // The longest step makes the accumulator saturate.
    set_timing('1, 8'd255);
    send_frame(CMD_ACCUMULATE, 32'h7FFF_FFFF);
    send_frame(CMD_ACCUMULATE, 32'h7FFF_FFFF);
    send_frame(CMD_ACCUMULATE, 32'h7FFF_FFFF);
    send_frame(CMD_ACCUMULATE, 32'h7FFF_FFFF);
    send_frame(CMD_CLEAR, 32'h8000_0000);
    send_frame(CMD_ACCUMULATE, 32'h8000_0001);
    wait_drained();

    // A catch-up limit of zero reports no steps at all.
    set_timing(32'd1, 8'd0);
    send_frame(CMD_ACCUMULATE, 32'sd5);
    wait_drained();

    // A short step gives a fraction of two thirds, then a carry into a step.
    set_timing(32'd3, 8'd255);
    send_frame(CMD_ACCUMULATE, 32'sd2);
    send_frame(CMD_ACCUMULATE, 32'sd2);
    wait_drained();

    // Random phases over a range of settings, extremes included.
    set_timing(STEP_LENGTH_RST, MAX_CATCHUP_RST);
    run_frames(300);
    set_timing(32'd1, 8'd0);
    run_frames(100);
    set_timing('0, 8'd255);
    run_frames(100);
    set_timing('1, 8'd255);
    run_frames(150);
    set_timing(STEP_W'($urandom_range(1, 5000)), COUNT_W'($urandom_range(0, 16)));
    run_frames(250);
    set_timing(STEP_W'($urandom), COUNT_W'($urandom_range(0, 255)));
    run_frames(200);
    set_timing(32'd4166667, 8'd1);
    run_frames(150);
    set_timing(STEP_W'($urandom_range(1, 1 << 20)), COUNT_W'($urandom_range(0, 255)));
    run_frames(200);

    // Let any late or stray result show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("** fixed_timestep_accumulator: PASSED **");
    end else begin
      $display("** fixed_timestep_accumulator: FAILED **");
    end
    $finish;
  end

endmodule
